/* hdl/dqs_pkg.sv */
package dqs_pkg;

   // Default sizing of the ring store
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Field widths of the transaction payloads
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd3;

   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] popped_value;
      pos_type                   match_position;
      count_type                 element_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SEARCH
   } state_type;

endpackage

/* hdl/dqs_store.sv */
module dqs_store #(
   parameter int DEPTH      = dqs_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dqs_ctrl.sv */
module dqs_ctrl #(
   parameter int DEPTH      = dqs_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  dqs_pkg::req_type              req_data,
   output logic                          busy,
   output logic                          mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
   output logic [DATA_WIDTH-1:0]         mem_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]         mem_rd_data,
   output logic                          rsp_fire,
   output dqs_pkg::rsp_type              rsp_next
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = (DATA_WIDTH < dqs_pkg::VALUE_W) ? DATA_WIDTH : dqs_pkg::VALUE_W;
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] FULL    = CW'(DEPTH);

   dqs_pkg::state_type state_ff, state_in;
   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;

   logic                  accept;
   logic                  is_empty;
   logic                  is_full;
   logic [DATA_WIDTH-1:0] val_word;
   logic [CW-1:0]         occ_dec;
   logic [AW:0]           back_sum;
   logic [AW:0]           tail_sum;
   logic [AW-1:0]         back_idx;
   logic [AW-1:0]         tail_idx;
   logic [AW-1:0]         front_dec;
   logic [AW-1:0]         front_inc;
   logic [AW-1:0]         ptr_inc;
   logic [CW-1:0]         idx_plus;
   logic                  hit;
   logic                  last;

   assign busy     = (state_ff != dqs_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign is_empty = (occ_ff == '0);
   assign is_full  = (occ_ff >= FULL);

   // Incoming word masked to the stored width
   always_comb begin
      val_word = '0;
      val_word[KW-1:0] = req_data.value[KW-1:0];
   end

   // Ring address arithmetic: one compare and subtract for the wrap
   assign occ_dec   = occ_ff - 1'b1;
   assign back_sum  = {1'b0, front_ff} + {1'b0, occ_ff[AW-1:0]};
   assign tail_sum  = {1'b0, front_ff} + {1'b0, occ_dec[AW-1:0]};
   assign back_idx  = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : back_sum[AW-1:0];
   assign tail_idx  = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
   assign front_dec = (front_ff == '0) ? LAST : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST) ? '0 : front_ff + 1'b1;
   assign ptr_inc   = (ptr_ff == LAST) ? '0 : ptr_ff + 1'b1;

   // Search compare on the element read in the previous cycle
   assign idx_plus = idx_ff + 1'b1;
   assign hit      = (mem_rd_data == key_ff);
   assign last     = (idx_plus == occ_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dqs_pkg::ST_IDLE: begin
            if (accept && !is_empty) begin
               if (req_data.kind == dqs_pkg::KIND_POP_FRONT ||
                   req_data.kind == dqs_pkg::KIND_POP_BACK) begin
                  state_in = dqs_pkg::ST_POP;
               end else if (req_data.kind == dqs_pkg::KIND_SEARCH) begin
                  state_in = dqs_pkg::ST_SEARCH;
               end
            end
         end
         dqs_pkg::ST_POP: begin
            state_in = dqs_pkg::ST_IDLE;
         end
         dqs_pkg::ST_SEARCH: begin
            if (hit || last) begin
               state_in = dqs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dqs_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory accesses, pointer updates and the result
   always_comb begin
      front_in    = front_ff;
      occ_in      = occ_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      key_in      = key_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = back_idx;
      mem_wr_data = val_word;
      mem_rd_en   = 1'b0;
      mem_rd_addr = front_ff;
      rsp_fire    = 1'b0;
      rsp_next.status         = dqs_pkg::STAT_OK;
      rsp_next.popped_value   = '0;
      rsp_next.match_position = '0;
      case (state_ff)
         dqs_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  dqs_pkg::KIND_PUSH_FRONT,
                  dqs_pkg::KIND_PUSH_BACK: begin
                     rsp_fire = 1'b1;
                     if (is_full) begin
                        rsp_next.status = dqs_pkg::STAT_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        occ_in    = occ_ff + 1'b1;
                        if (req_data.kind == dqs_pkg::KIND_PUSH_FRONT) begin
                           mem_wr_addr = front_dec;
                           front_in    = front_dec;
                        end
                     end
                  end
                  dqs_pkg::KIND_POP_FRONT,
                  dqs_pkg::KIND_POP_BACK: begin
                     if (is_empty) begin
                        rsp_fire        = 1'b1;
                        rsp_next.status = dqs_pkg::STAT_EMPTY;
                     end else begin
                        mem_rd_en = 1'b1;
                        occ_in    = occ_dec;
                        if (req_data.kind == dqs_pkg::KIND_POP_FRONT) begin
                           front_in = front_inc;
                        end else begin
                           mem_rd_addr = tail_idx;
                        end
                     end
                  end
                  dqs_pkg::KIND_SEARCH: begin
                     if (is_empty) begin
                        rsp_fire        = 1'b1;
                        rsp_next.status = dqs_pkg::STAT_EMPTY;
                     end else begin
                        mem_rd_en = 1'b1;
                        key_in    = val_word;
                        idx_in    = '0;
                        ptr_in    = front_inc;
                     end
                  end
                  default: begin
                     rsp_fire = 1'b1;
                  end
               endcase
            end
         end
         dqs_pkg::ST_POP: begin
            rsp_fire = 1'b1;
            rsp_next.popped_value[KW-1:0] = mem_rd_data[KW-1:0];
         end
         dqs_pkg::ST_SEARCH: begin
            // Read ahead one entry while the current one is compared
            mem_rd_en   = 1'b1;
            mem_rd_addr = ptr_ff;
            ptr_in      = ptr_inc;
            idx_in      = idx_plus;
            if (hit) begin
               rsp_fire                = 1'b1;
               rsp_next.match_position = dqs_pkg::pos_type'(idx_ff);
            end else if (last) begin
               rsp_fire        = 1'b1;
               rsp_next.status = dqs_pkg::STAT_MISS;
            end
         end
         default: begin
         end
      endcase
      rsp_next.element_count = dqs_pkg::count_type'(occ_in);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqs_pkg::ST_IDLE;
         front_ff <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         occ_ff   <= occ_in;
      end
   end

   // Search walk registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      ptr_ff <= ptr_in;
      key_ff <= key_in;
   end

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL)
      else $error("occupancy above depth");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !mem_wr_en)
      else $error("store written while an operation is in flight");

   a_search_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dqs_pkg::ST_SEARCH) |-> (idx_ff < occ_ff))
      else $error("search walked past the last element");

   a_pop_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dqs_pkg::ST_POP) |-> (rsp_fire && $past(mem_rd_en)))
      else $error("pop result without a store read");

   a_search_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dqs_pkg::ST_SEARCH) |-> ($stable(occ_ff) && $stable(front_ff)))
      else $error("queue state moved during a search");
`endif

endmodule

/* hdl/circular_deque_with_search.sv */
// Bounded double-ended queue of signed words with a linear search.
//
// Request side: drive req_data (kind, value) and raise start. The
// transaction is taken at a rising edge where start is high and busy is
// low. Kinds: push front, push back, pop front, pop back, search from front.
// Result side: every transaction yields exactly one result on rsp_data,
// flagged by rsp_valid for a single cycle. The receiver has no way to stall;
// it must sample the result in that cycle.
//
// Result path: a push, a refused operation or an unused kind has its
// result registered at the accepting edge; a pop first reads the store
// and then registers the popped word; a search reads the front entry,
// then compares each read entry while reading the next, and registers
// the result on a hit or after the last entry.
// The search walks the ring store one entry per cycle through its single
// read port. busy stays low for pushes, so those may issue every cycle.
// Reset (synchronous) empties the queue; stored words are not cleared.
module circular_deque_with_search #(
   parameter int DEPTH      = dqs_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dqs_pkg::req_type req_data,
   output logic             rsp_valid,
   output dqs_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   logic                  rsp_fire;
   dqs_pkg::rsp_type      rsp_next;
   logic                  rsp_valid_ff;
   dqs_pkg::rsp_type      rsp_data_ff;

   dqs_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .busy        (busy),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_fire    (rsp_fire),
      .rsp_next    (rsp_next)
   );

   dqs_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Result register: strobe for one cycle per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
